// ===== rtl/rhh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared types and constants for the Robin Hood hash table unit.
// ----------------------------------------------------------------------------
package rhh_pkg;
    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int DIST_W     = IDX_W + 1;
    localparam int HASH_W     = 48;
    localparam int VALUE_W    = 32;
    localparam int LIMIT_W    = 10;
    localparam int COUNT_W    = IDX_W + 1;
    localparam int ENTRY_W    = HASH_W + VALUE_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(614);

    typedef enum logic [2:0] {
        ACT_SET    = 3'd0,
        ACT_GET    = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_NEXT   = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_INSERTED = 4'd0,
        ST_REPLACED = 4'd1,
        ST_FOUND    = 4'd2,
        ST_MISSING  = 4'd3,
        ST_REMOVED  = 4'd4,
        ST_FULL     = 4'd5,
        ST_ITEM     = 4'd6,
        ST_END      = 4'd7,
        ST_CLEARED  = 4'd8
    } t_status;
endpackage

// ===== rtl/rhh_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhh_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/robin_hood_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Sequence: each probed slot is read, then compared; a set adds a step per swap, and
//   a remove moves each shifted entry through read, evaluate, clear and next states.
//   o_valid is registered from the done state. Next reads and compares each slot
//   scanned, clear sweeps all SLOTS slots, and a refused or unknown beat goes to done.
// Throughput: one beat at a time, bounded by the single-port slot memories.
// Reset: synchronous, active low; a pass over every slot then zeroes every distance.
// ----------------------------------------------------------------------------
// robin_hood_hash_table_unit
// Open-addressed Robin Hood hash table keyed by a 48-bit hash.
// ----------------------------------------------------------------------------
module robin_hood_hash_table_unit
    import rhh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LIMIT_W-1:0]   i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_action,
    input  logic [HASH_W-1:0]    i_key_hash,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic [IDX_W:0]       i_scan_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_status,
    output logic [VALUE_W-1:0]   o_value_out,
    output logic [HASH_W-1:0]    o_hash_out,
    output logic [IDX_W:0]       o_next_index,
    output logic [LIMIT_W-1:0]   o_entry_total
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_READ, S_EVAL, S_STEP, S_SHIFT_RD, S_SHIFT_EV,
        S_SHIFT_CLR, S_SHIFT_NX, S_DONE
    } t_state;

    // One memory for distance, one for hash+value payload; both share an address.
    logic               r_dwe, r_pwe;
    logic [IDX_W-1:0]   r_addr;
    logic [DIST_W-1:0]  r_dwdata;
    logic [ENTRY_W-1:0] r_pwdata;
    logic [DIST_W-1:0]  w_drd;
    logic [ENTRY_W-1:0] w_prd;

    rhh_ram #(.WIDTH(DIST_W), .DEPTH(SLOTS)) u_dist (
        .i_clk(i_clk), .i_we(r_dwe), .i_addr(r_addr),
        .i_wdata(r_dwdata), .o_rdata(w_drd)
    );
    rhh_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_payload (
        .i_clk(i_clk), .i_we(r_pwe), .i_addr(r_addr),
        .i_wdata(r_pwdata), .o_rdata(w_prd)
    );

    t_state             r_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [COUNT_W-1:0] r_count;
    t_action            r_act;
    logic               r_clr;    // sweep was started by a clear beat
    logic [HASH_W-1:0]  r_ch;     // carried hash
    logic [VALUE_W-1:0] r_cv;     // carried value
    logic [DIST_W-1:0]  r_cd;     // carried distance
    logic [HASH_W-1:0]  r_key;    // original key, for get/remove compare
    logic [COUNT_W-1:0] r_steps;  // probe bound counter
    logic [IDX_W:0]     r_scan;
    logic [IDX_W-1:0]   r_prev;

    logic [HASH_W-1:0]  w_rh;
    logic [VALUE_W-1:0] w_rv;
    logic [IDX_W-1:0]   w_next_addr;
    assign w_rh = w_prd[ENTRY_W-1:VALUE_W];
    assign w_rv = w_prd[VALUE_W-1:0];
    assign w_next_addr = r_addr + IDX_W'(1);  // wraps naturally at SLOTS

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_limit  <= LIMIT_RESET;
            r_count  <= '0;
            r_addr   <= '0;
            r_dwe    <= 1'b1;
            r_dwdata <= '0;
            r_pwe    <= 1'b0;
            r_clr    <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_dwe <= 1'b0;
            r_pwe <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    // sweep distance memory to zero, one slot a cycle
                    if (r_addr == IDX_W'(SLOTS - 1)) begin
                        r_addr <= '0;
                        r_clr  <= 1'b0;
                        if (r_clr) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_addr   <= w_next_addr;
                        r_dwe    <= 1'b1;
                        r_dwdata <= '0;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_act        <= t_action'(i_action);
                        r_ch         <= i_key_hash;
                        r_key        <= i_key_hash;
                        r_cv         <= i_value;
                        r_cd         <= DIST_W'(1);
                        r_steps      <= '0;
                        r_scan       <= i_scan_index;
                        o_status     <= ST_MISSING;
                        o_value_out  <= '0;
                        o_hash_out   <= '0;
                        o_next_index <= '0;
                        r_addr       <= i_key_hash[IDX_W-1:0];
                        unique case (i_action)
                            ACT_SET: begin
                                if (r_count >= COUNT_W'(r_limit)
                                        || r_count >= COUNT_W'(SLOTS)) begin
                                    o_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            ACT_GET, ACT_REMOVE: r_state <= S_READ;
                            ACT_NEXT: begin
                                o_status     <= ST_END;
                                o_next_index <= i_scan_index;
                                if (i_scan_index < (IDX_W+1)'(SLOTS)) begin
                                    r_addr  <= i_scan_index[IDX_W-1:0];
                                    r_state <= S_READ;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            ACT_CLEAR: begin
                                o_status <= ST_CLEARED;
                                r_count  <= '0;
                                r_clr    <= 1'b1;
                                r_addr   <= '0;
                                r_dwe    <= 1'b1;
                                r_dwdata <= '0;
                                r_state  <= S_CLR;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_READ;
                    unique case (r_act)
                        ACT_SET: begin
                            if (w_drd == '0) begin
                                r_dwe    <= 1'b1;
                                r_dwdata <= r_cd;
                                r_pwe    <= 1'b1;
                                r_pwdata <= {r_ch, r_cv};
                                r_count  <= r_count + COUNT_W'(1);
                                o_status <= ST_INSERTED;
                                r_state  <= S_DONE;
                            end else if (w_rh == r_ch) begin
                                o_value_out <= w_rv;
                                r_pwe       <= 1'b1;
                                r_pwdata    <= {r_ch, r_cv};
                                o_status    <= ST_REPLACED;
                                r_state     <= S_DONE;
                            end else begin
                                if (w_drd < r_cd) begin
                                    // hold the address until the swap is written
                                    r_dwe    <= 1'b1;
                                    r_dwdata <= r_cd;
                                    r_pwe    <= 1'b1;
                                    r_pwdata <= {r_ch, r_cv};
                                    r_ch     <= w_rh;
                                    r_cv     <= w_rv;
                                    r_cd     <= w_drd + DIST_W'(1);
                                    r_state  <= S_STEP;
                                end else begin
                                    r_cd   <= r_cd + DIST_W'(1);
                                    r_addr <= w_next_addr;
                                end
                                r_steps <= r_steps + COUNT_W'(1);
                                if (r_steps == COUNT_W'(SLOTS - 1)) begin
                                    o_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                        end
                        ACT_GET, ACT_REMOVE: begin
                            if (w_drd == '0) begin
                                r_state <= S_DONE;
                            end else if (w_rh == r_key) begin
                                o_value_out <= w_rv;
                                if (r_act == ACT_GET) begin
                                    o_status <= ST_FOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    // empty the found slot, then walk the chain
                                    r_dwe    <= 1'b1;
                                    r_dwdata <= '0;
                                    r_prev   <= r_addr;
                                    r_steps  <= '0;
                                    o_status <= ST_REMOVED;
                                    if (r_count != '0) begin
                                        r_count <= r_count - COUNT_W'(1);
                                    end
                                    r_state  <= S_SHIFT_NX;
                                end
                            end else begin
                                r_addr  <= w_next_addr;
                                r_steps <= r_steps + COUNT_W'(1);
                                if (r_steps == COUNT_W'(SLOTS - 1)) begin
                                    r_state <= S_DONE;
                                end
                            end
                        end
                        default: begin
                            // next-occupied scan
                            o_next_index <= r_scan + (IDX_W+1)'(1);
                            r_scan       <= r_scan + (IDX_W+1)'(1);
                            if (w_drd != '0) begin
                                o_status    <= ST_ITEM;
                                o_value_out <= w_rv;
                                o_hash_out  <= w_rh;
                                r_state     <= S_DONE;
                            end else if (r_scan == (IDX_W+1)'(SLOTS - 1)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_addr <= w_next_addr;
                            end
                        end
                    endcase
                end
                S_STEP: begin
                    // swap lands this cycle; advance to the next slot
                    r_addr  <= w_next_addr;
                    r_state <= S_READ;
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_EV;
                end
                S_SHIFT_EV: begin
                    if (w_drd <= DIST_W'(1) || r_steps == COUNT_W'(SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        // move entry one slot back, then clear its old place
                        r_ch    <= w_rh;
                        r_cv    <= w_rv;
                        r_cd    <= w_drd - DIST_W'(1);
                        r_prev  <= r_addr;
                        r_addr  <= r_prev;
                        r_pwe   <= 1'b1;
                        r_pwdata <= w_prd;
                        r_dwe   <= 1'b1;
                        r_dwdata <= w_drd - DIST_W'(1);
                        r_steps <= r_steps + COUNT_W'(1);
                        r_state <= S_SHIFT_CLR;
                    end
                end
                S_SHIFT_CLR: begin
                    r_addr   <= r_prev;
                    r_dwe    <= 1'b1;
                    r_dwdata <= '0;
                    r_state  <= S_SHIFT_NX;
                end
                S_SHIFT_NX: begin
                    r_addr  <= w_next_addr;
                    r_prev  <= r_addr;
                    r_state <= S_SHIFT_RD;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    if (o_valid && i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_entry_total = r_count[LIMIT_W-1:0];
endmodule
